[design/cbm_pkg.sv]
// Shared types and codes for the cartridge bank mapper with IRQ counter.
// Used by every module of the block.
package cbm_pkg;

  // Item operation codes.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_XLATE = 2'd2;

  // Region codes reported by a translate request.
  localparam logic [2:0] REGION_PATTERN   = 3'd0;
  localparam logic [2:0] REGION_NAMETABLE = 3'd1;
  localparam logic [2:0] REGION_WRAM      = 3'd2;
  localparam logic [2:0] REGION_PROGRAM   = 3'd3;
  localparam logic [2:0] REGION_NONE      = 3'd4;

  // Translate space codes.
  localparam logic SPACE_CPU = 1'b0;
  localparam logic SPACE_PPU = 1'b1;

  // Program bank seen at E000-FFFF on the CPU bus.
  localparam logic [7:0] FIXED_BANK = 8'hFF;

  // The counter is loaded with at most 15 bits and cleared on overflow.
  localparam int CNT_W = 15;

  // One input request.
  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] address;
    logic [7:0]  data;
    logic        space;
    logic [7:0]  cycles;
  } item_t;

  // Translate and decode outcome from the bank registers.
  typedef struct packed {
    logic [7:0] bank;
    logic [2:0] region;
    logic       sound_access;
  } xlate_t;

endpackage

[design/cbm_ifs.sv]
// Valid/ready channel interfaces for the mapper's request and result sides.
// Depends on nothing but plain logic types.
interface cbm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] address;
  logic [7:0]  data;
  logic        space;
  logic [7:0]  cycles;

  modport source (output valid, output operation, output address, output data,
                  output space, output cycles, input ready);
  modport sink   (input valid, input operation, input address, input data,
                  input space, input cycles, output ready);
endinterface

interface cbm_out_if;
  logic       valid;
  logic       ready;
  logic       irq_line;
  logic [7:0] bank;
  logic [2:0] region;
  logic       sound_access;

  modport source (output valid, output irq_line, output bank, output region,
                  output sound_access, input ready);
  modport sink   (input valid, input irq_line, input bank, input region,
                  input sound_access, output ready);
endinterface

[design/cbm_bank_regs.sv]
// Pattern, nametable and program bank registers with write decode and
// address translate. Depends on cbm_pkg.
module cbm_bank_regs (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           upd,
  input  cbm_pkg::item_t item,
  output cbm_pkg::xlate_t xl
);

  logic [7:0] pattern_r [8];
  logic [7:0] program_r [4];
  // Only bit 0 of a nametable page is ever used.
  logic [3:0] ntpage_r;

  logic [15:0] a;
  logic        is_write;
  logic        wr_pattern;
  logic        wr_ntpage;
  logic        wr_program;
  logic        snd;

  assign a        = item.address;
  assign is_write = upd && (item.operation == cbm_pkg::OP_WRITE);

  // Write decode by CPU address range.
  always_comb begin
    wr_pattern = 1'b0;
    wr_ntpage  = 1'b0;
    wr_program = 1'b0;
    snd        = 1'b0;
    if (item.operation == cbm_pkg::OP_WRITE) begin
      if (a[15:14] == 2'b10) begin
        wr_pattern = !a[10];
      end else if (a[15:13] == 3'b110) begin
        wr_ntpage = !a[10];
      end else if (a[15:13] == 3'b111) begin
        if (a[12] && a[11]) begin
          snd = 1'b1;
        end else begin
          wr_program = !a[10];
        end
      end
    end
  end

  // Bank register updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) pattern_r[i] <= 8'(i);
      for (int i = 0; i < 4; i++) program_r[i] <= 8'(i);
      ntpage_r <= 4'b1100;
    end else if (is_write) begin
      if (wr_pattern) pattern_r[a[13:11]] <= item.data;
      if (wr_ntpage)  ntpage_r[a[12:11]]  <= item.data[0];
      if (wr_program) program_r[a[12:11]] <= item.data;
    end
  end

  // Address translate for CPU and PPU buses.
  always_comb begin
    xl.bank         = 8'd0;
    xl.region       = cbm_pkg::REGION_NONE;
    xl.sound_access = snd;
    if (item.operation == cbm_pkg::OP_XLATE) begin
      if (item.space == cbm_pkg::SPACE_CPU) begin
        if (a[15:13] == 3'b111) begin
          xl.bank   = cbm_pkg::FIXED_BANK;
          xl.region = cbm_pkg::REGION_PROGRAM;
        end else if (a[15]) begin
          xl.bank   = program_r[a[14:13]];
          xl.region = cbm_pkg::REGION_PROGRAM;
        end else if (a[14:13] == 2'b11) begin
          xl.region = cbm_pkg::REGION_WRAM;
        end
      end else if (!a[13]) begin
        xl.bank   = pattern_r[a[12:10]];
        xl.region = cbm_pkg::REGION_PATTERN;
      end else begin
        xl.bank   = {7'd0, ntpage_r[a[11:10]]};
        xl.region = cbm_pkg::REGION_NAMETABLE;
      end
    end
  end

endmodule

[design/cbm_irq_counter.sv]
// Cycle-driven IRQ counter with its load registers, enable and pending flag.
// Depends on cbm_pkg.
module cbm_irq_counter (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           upd,
  input  cbm_pkg::item_t item,
  output logic           pending_nxt
);

  logic [cbm_pkg::CNT_W-1:0] count_r, count_nxt;
  logic                      enable_r, enable_nxt;
  logic                      pending_r;
  logic                      irq_reg;
  logic [cbm_pkg::CNT_W:0]   sum;

  // IRQ registers live at 8000-BFFF with bit 10 set; bit 13 picks the half.
  assign irq_reg = (item.address[15:14] == 2'b10) && item.address[10];
  assign sum     = {1'b0, count_r} + {{(cbm_pkg::CNT_W + 1 - 8){1'b0}}, item.cycles};

  // Next state for the item at hand.
  always_comb begin
    count_nxt   = count_r;
    enable_nxt  = enable_r;
    pending_nxt = pending_r;
    if (item.operation == cbm_pkg::OP_WRITE && irq_reg) begin
      if (item.address[13]) begin
        count_nxt[cbm_pkg::CNT_W-1:8] = item.data[cbm_pkg::CNT_W-9:0];
        enable_nxt  = item.data[7];
        pending_nxt = 1'b0;
      end else begin
        count_nxt[7:0] = item.data;
      end
    end else if (item.operation == cbm_pkg::OP_TICK && enable_r) begin
      if (sum[cbm_pkg::CNT_W]) begin
        count_nxt   = '0;
        enable_nxt  = 1'b0;
        pending_nxt = 1'b1;
      end else begin
        count_nxt = sum[cbm_pkg::CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      enable_r  <= 1'b0;
      pending_r <= 1'b0;
    end else if (upd) begin
      count_r   <= count_nxt;
      enable_r  <= enable_nxt;
      pending_r <= pending_nxt;
    end
  end

  // The counter never runs while an IRQ is pending.
  a_no_en_and_pend: assert property (@(posedge clk) disable iff (!rst_n)
    !(enable_r && pending_r))
    else $error("IRQ enabled while pending");

  // A pending IRQ only comes from an enabled counter.
  a_rise_from_en: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(pending_r) |-> $past(enable_r))
    else $error("IRQ raised with counter disabled");

  // Raising the IRQ also clears the counter.
  a_rise_clears: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(pending_r) |-> (count_r == '0))
    else $error("counter not cleared on IRQ");

endmodule

[design/cartridge_bank_mapper_irq_top.sv]
// Top level of the cartridge bank mapper: request register, result register
// and handshake control. Depends on cbm_pkg, cbm_ifs, cbm_bank_regs and
// cbm_irq_counter.
//
// Usage:
//   Requests arrive on in_ch (valid/ready). Each carries an operation: a CPU
//   register write, a cycle tick that advances the IRQ counter, or an address
//   translate for the CPU or PPU bus. Every request yields exactly one result
//   on out_ch with the IRQ level after the request, the bank and region of a
//   translate, and a flag for writes to the sound range F800-FFFF.
//   An accepted request passes through the request register and then the
//   result register; the bank and counter logic fill the result register
//   from the request register.
//   Throughput is one request per cycle while out_ch takes results, set by
//   the single pass through the decode and the 16-bit counter add.
//   Reset (rst_n low, synchronous) empties both registers, restores the
//   bank registers to their power-on banks and clears the counter, enable
//   and pending IRQ.
//   When out_ch stalls, the result register holds its result and the request
//   register holds one more request; in_ch.ready drops only when both are
//   full and the output is not being taken.
module cartridge_bank_mapper_irq_top (
  input  logic      clk,
  input  logic      rst_n,
  cbm_in_if.sink    in_ch,
  cbm_out_if.source out_ch
);

  logic            s1_valid_r;
  cbm_pkg::item_t  s1_item_r;
  logic            s1_move;
  logic            in_fire;

  logic            out_valid_r;
  logic            out_irq_r;
  cbm_pkg::xlate_t out_xl_r;

  cbm_pkg::xlate_t xl;
  logic            pending_nxt;

  // Handshake control.
  assign s1_move     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_move;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Request register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.operation <= in_ch.operation;
      s1_item_r.address   <= in_ch.address;
      s1_item_r.data      <= in_ch.data;
      s1_item_r.space     <= in_ch.space;
      s1_item_r.cycles    <= in_ch.cycles;
    end
  end

  cbm_bank_regs u_banks (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (s1_move),
    .item  (s1_item_r),
    .xl    (xl)
  );

  cbm_irq_counter u_irq (
    .clk         (clk),
    .rst_n       (rst_n),
    .upd         (s1_move),
    .item        (s1_item_r),
    .pending_nxt (pending_nxt)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_irq_r <= pending_nxt;
      out_xl_r  <= xl;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.irq_line     = out_irq_r;
  assign out_ch.bank         = out_xl_r.bank;
  assign out_ch.region       = out_xl_r.region;
  assign out_ch.sound_access = out_xl_r.sound_access;

  // A held request is not dropped while the output stalls.
  a_hold_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ch.ready) |=> s1_valid_r)
    else $error("request lost under output stall");

  // Both registers full and stalled means no new request is taken.
  a_full_block: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("request accepted with pipeline full");

endmodule

[dv/tb_cartridge_bank_mapper_irq_top.sv]
// Testbench for cartridge_bank_mapper_irq_top: drives write, tick and translate requests
// and checks every result against a predictor of the bank registers and IRQ counter.
// Depends on cbm_pkg, the cbm_in_if/cbm_out_if interfaces and the top level.
module tb_cartridge_bank_mapper_irq_top;

  // Expected contents of one result.
  typedef struct packed {
    logic       irq_line;
    logic [7:0] bank;
    logic [2:0] region;
    logic       sound_access;
  } mapper_result_t;

  localparam int RANDOM_PER_PHASE = 560;
  localparam int MAX_REPORTS      = 10;

  logic clk;
  logic rst_n;

  cbm_in_if  in_ch();
  cbm_out_if out_ch();

  cartridge_bank_mapper_irq_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predicted mapper state.
  logic [7:0]  prg_bank [4];
  logic [7:0]  chr_bank [8];
  logic [7:0]  nt_page  [4];
  logic [15:0] irq_cnt;
  logic        irq_en;
  logic        irq_pend;

  mapper_result_t expected_results [$];
  int mismatches;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_off_req;
  int unsigned stall_left;

  // Clock.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Power-on state of the predicted registers.
  task automatic reset_mapper_model();
    for (int i = 0; i < 4; i++) prg_bank[i] = 8'(i);
    for (int i = 0; i < 8; i++) chr_bank[i] = 8'(i);
    for (int i = 0; i < 4; i++) nt_page[i] = 8'(i >> 1);
    irq_cnt  = '0;
    irq_en   = 1'b0;
    irq_pend = 1'b0;
  endtask

  // Apply one accepted request to the predicted state and form its result.
  task automatic predict_mapper_result(input cbm_pkg::item_t req,
                                       output mapper_result_t res);
    logic [15:0] a;
    a = req.address;
    res.bank         = '0;
    res.region       = cbm_pkg::REGION_NONE;
    res.sound_access = 1'b0;
    case (req.operation)
      cbm_pkg::OP_WRITE: begin
        if (a[15:14] == 2'b10) begin
          // 8000-BFFF: IRQ counter when bit 10 is set, else a pattern bank.
          if (a[10]) begin
            if (a[13]) begin
              irq_cnt[14:8] = req.data[6:0];
              irq_cnt[15]   = 1'b0;
              irq_en        = req.data[7];
              irq_pend      = 1'b0;
            end else begin
              irq_cnt[7:0] = req.data;
            end
          end else begin
            chr_bank[a[13:11]] = req.data;
          end
        end else if (a[15:13] == 3'b110) begin
          if (!a[10]) nt_page[a[12:11]] = req.data;
        end else if (a[15:13] == 3'b111) begin
          // F800-FFFF goes to the sound unit; the rest of E000-F7FF is program banks.
          if (a[12] && a[11]) res.sound_access = 1'b1;
          else if (!a[10]) prg_bank[a[12:11]] = req.data;
        end
      end
      cbm_pkg::OP_TICK: begin
        if (irq_en) begin
          irq_cnt = irq_cnt + 16'(req.cycles);
          if (irq_cnt > 16'h7FFF) begin
            irq_pend = 1'b1;
            irq_en   = 1'b0;
            irq_cnt  = '0;
          end
        end
      end
      cbm_pkg::OP_XLATE: begin
        if (req.space == cbm_pkg::SPACE_CPU) begin
          if (a >= 16'hE000) begin
            res.bank   = cbm_pkg::FIXED_BANK;
            res.region = cbm_pkg::REGION_PROGRAM;
          end else if (a >= 16'h8000) begin
            res.bank   = prg_bank[a[14:13]];
            res.region = cbm_pkg::REGION_PROGRAM;
          end else if (a >= 16'h6000) begin
            res.region = cbm_pkg::REGION_WRAM;
          end
        end else if (!a[13]) begin
          res.bank   = chr_bank[a[12:10]];
          res.region = cbm_pkg::REGION_PATTERN;
        end else begin
          res.bank   = {7'd0, nt_page[a[11:10]][0]};
          res.region = cbm_pkg::REGION_NAMETABLE;
        end
      end
      default: ;
    endcase
    res.irq_line = irq_pend;
  endtask

  // Offer one request, record its expected result on acceptance, then maybe idle.
  task automatic send_request(input cbm_pkg::item_t req);
    mapper_result_t res;
    in_ch.valid     <= 1'b1;
    in_ch.operation <= req.operation;
    in_ch.address   <= req.address;
    in_ch.data      <= req.data;
    in_ch.space     <= req.space;
    in_ch.cycles    <= req.cycles;
    do @(posedge clk); while (!in_ch.ready);
    predict_mapper_result(req, res);
    expected_results.push_back(res);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Request with random contents in the fields the operation ignores.
  function automatic cbm_pkg::item_t noisy_item(input logic [1:0] op);
    cbm_pkg::item_t req;
    req.operation = op;
    req.address   = 16'($urandom);
    req.data      = 8'($urandom);
    req.space     = 1'($urandom);
    req.cycles    = 8'($urandom);
    return req;
  endfunction

  task automatic cpu_write(input logic [15:0] addr, input logic [7:0] value);
    cbm_pkg::item_t req;
    req         = noisy_item(cbm_pkg::OP_WRITE);
    req.address = addr;
    req.data    = value;
    send_request(req);
  endtask

  task automatic cycle_tick(input logic [7:0] count);
    cbm_pkg::item_t req;
    req        = noisy_item(cbm_pkg::OP_TICK);
    req.cycles = count;
    send_request(req);
  endtask

  task automatic xlate_query(input logic space, input logic [15:0] addr);
    cbm_pkg::item_t req;
    req         = noisy_item(cbm_pkg::OP_XLATE);
    req.space   = space;
    req.address = addr;
    send_request(req);
  endtask

  // Stop offering and wait until every expected result has arrived.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  // Receiver: random ready, or a held-off stretch when one is requested.
  initial begin
    out_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req > 0) begin
        stall_left   = hold_off_req;
        hold_off_req = 0;
      end
      if (stall_left > 0) begin
        stall_left   = stall_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    mapper_result_t got;
    mapper_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.irq_line, out_ch.bank, out_ch.region, out_ch.sound_access};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Unexpected result: irq=%0b bank=%02h region=%0d sound=%0b",
                   got.irq_line, got.bank, got.region, got.sound_access);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"Mismatch: expected irq=%0b bank=%02h region=%0d sound=%0b,",
                      " got irq=%0b bank=%02h region=%0d sound=%0b"},
                     want.irq_line, want.bank, want.region, want.sound_access,
                     got.irq_line, got.bank, got.region, got.sound_access);
        end
      end
    end
  end

  // Translate every kind of address against the power-on banks.
  task automatic test_power_on_banks();
    xlate_query(cbm_pkg::SPACE_CPU, 16'h0000);
    xlate_query(cbm_pkg::SPACE_CPU, 16'h6000);
    xlate_query(cbm_pkg::SPACE_CPU, 16'h8000);
    xlate_query(cbm_pkg::SPACE_CPU, 16'hFFFF);
    xlate_query(cbm_pkg::SPACE_PPU, 16'h1C00);
    xlate_query(cbm_pkg::SPACE_PPU, 16'hFFFF);
  endtask

  // Each write target, the ignored holes and the sound range, read back by translate.
  task automatic test_register_writes();
    cpu_write(16'h8000, 8'hFF);
    cpu_write(16'hB800, 8'h00);
    cpu_write(16'hC000, 8'hA5);
    cpu_write(16'hDC00, 8'h77);
    cpu_write(16'hF000, 8'h34);
    cpu_write(16'hF800, 8'h55);
    cpu_write(16'h7FFF, 8'h99);
    xlate_query(cbm_pkg::SPACE_PPU, 16'h0000);
    xlate_query(cbm_pkg::SPACE_PPU, 16'h2000);
    xlate_query(cbm_pkg::SPACE_CPU, 16'hC000);
  endtask

  // Load the counter just under overflow, cross it, tick while disabled, acknowledge.
  task automatic test_irq_counter();
    cpu_write(16'h8400, 8'hFE);
    cpu_write(16'hA400, 8'hFF);
    cycle_tick(8'd0);
    cycle_tick(8'd1);
    cycle_tick(8'd255);
    cycle_tick(8'd255);
    cpu_write(16'hA400, 8'h00);
  endtask

  // Random request, biased toward mapped writes and counter loads that overflow soon.
  task automatic random_request(output cbm_pkg::item_t req);
    int sel;
    sel = $urandom_range(99);
    if (sel < 40) begin
      req = noisy_item(cbm_pkg::OP_WRITE);
      case ($urandom_range(7))
        0: begin
          req.address[15:14] = 2'b10;
          req.address[10]    = 1'b0;
        end
        1: begin
          req.address[15:13] = 3'b110;
          req.address[10]    = 1'b0;
        end
        2: begin
          req.address[15:13] = 3'b111;
          req.address[10]    = 1'b0;
          if (req.address[12]) req.address[11] = 1'b0;
        end
        3: begin
          req.address[15:13] = 3'b100;
          req.address[10]    = 1'b1;
        end
        4: begin
          req.address[15:13] = 3'b101;
          req.address[10]    = 1'b1;
          req.data[7]        = ($urandom_range(3) != 0);
          if ($urandom_range(1)) req.data[6:2] = 5'h1F;
        end
        5: req.address[15:11] = 5'h1F;
        default: ;
      endcase
    end else if (sel < 75) begin
      req = noisy_item(cbm_pkg::OP_TICK);
      if ($urandom_range(1)) req.cycles = 8'($urandom_range(255, 200));
    end else begin
      req = noisy_item(cbm_pkg::OP_XLATE);
    end
  endtask

  task automatic test_random_traffic(input int count);
    cbm_pkg::item_t req;
    for (int i = 0; i < count; i++) begin
      random_request(req);
      send_request(req);
    end
  endtask

  // Hold the output off long enough that the block fills and stalls its input.
  task automatic test_output_stall();
    cbm_pkg::item_t req;
    @(posedge clk);
    hold_off_req = 150;
    @(negedge clk);
    for (int i = 0; i < 20; i++) begin
      random_request(req);
      send_request(req);
    end
  endtask

  // Run limit.
  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

  // Test sequence.
  initial begin
    mismatches      = 0;
    hold_off_req    = 0;
    send_idle_pct   = 10;
    recv_idle_pct   = 67;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.operation = cbm_pkg::OP_WRITE;
    in_ch.address   = '0;
    in_ch.data      = '0;
    in_ch.space     = cbm_pkg::SPACE_CPU;
    in_ch.cycles    = '0;
    reset_mapper_model();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_power_on_banks();
    test_register_writes();
    test_irq_counter();
    test_random_traffic(RANDOM_PER_PHASE);
    wait_drained();

    send_idle_pct = 67;
    recv_idle_pct = 10;
    test_random_traffic(RANDOM_PER_PHASE);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_stall();
    test_random_traffic(RANDOM_PER_PHASE);
    wait_drained();

    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
